// ===== rtl/pcmup_pkg.sv =====
package pcmup_pkg;

  localparam int RATE_W = 17;
  localparam int ACC_W = 18;
  localparam int SAMPLE_W = 16;
  localparam int CNT4_W = 4;
  localparam int FILL_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int PC_W = 4;

  localparam logic [RATE_W-1:0] RATE_MIN = 17'd8000;
  localparam logic [RATE_W-1:0] RATE_MAX = 17'd96000;
  localparam logic [RATE_W-1:0] OUTPUT_RATE_RST = 17'd44100;
  localparam logic [RATE_W-1:0] INPUT_RATE_RST = 17'd16000;
  localparam logic [CNT4_W-1:0] MAX_FRAMES = 4'd12;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_STEREO = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_PULL,
    OP_LINK_UP,
    OP_LINK_DOWN
  } op_e;

  typedef struct packed {
    op_e                        opcode;
    logic signed [SAMPLE_W-1:0] sample_in;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       underrun;
    logic [CNT4_W-1:0]          frames_made;
    logic [CNT4_W-1:0]          frames_dropped;
    logic                       status;
    logic [FILL_W-1:0]          fill_level;
  } out_t;

  typedef enum logic [3:0] {
    U_NOP,
    U_ACCEPT,
    U_LINK_UP,
    U_LINK_DOWN,
    U_PUSH_CHECK,
    U_ADD_PHASE,
    U_EMIT,
    U_PULL_READ,
    U_PULL_TAKE,
    U_FINISH
  } uop_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_BRANCH,
    J_LOOP
  } jmp_e;

  typedef struct packed {
    uop_e            uop;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    uop_e uop;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_ACCEPT = 4'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] PC_OPS = 4'd2;
  localparam logic [PC_W-1:0] PC_OP_PULL = 4'd3;
  localparam logic [PC_W-1:0] PC_OP_LINK_UP = 4'd4;
  localparam logic [PC_W-1:0] PC_OP_LINK_DOWN = 4'd5;
  localparam logic [PC_W-1:0] PC_PUSH = 4'd6;
  localparam logic [PC_W-1:0] PC_PHASE = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT = 4'd8;
  localparam logic [PC_W-1:0] PC_PULL = 4'd9;
  localparam logic [PC_W-1:0] PC_TAKE = 4'd10;
  localparam logic [PC_W-1:0] PC_FINISH = 4'd11;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{uop: U_NOP, jmp: J_GOTO, target: PC_ACCEPT};
    unique case (pc)
      PC_ACCEPT:       w = '{uop: U_ACCEPT,     jmp: J_LOOP,     target: PC_DISPATCH};
      PC_DISPATCH:     w = '{uop: U_NOP,        jmp: J_DISPATCH, target: PC_OPS};
      PC_OPS:          w = '{uop: U_NOP,        jmp: J_GOTO,     target: PC_PUSH};
      PC_OP_PULL:      w = '{uop: U_NOP,        jmp: J_GOTO,     target: PC_PULL};
      PC_OP_LINK_UP:   w = '{uop: U_LINK_UP,    jmp: J_GOTO,     target: PC_FINISH};
      PC_OP_LINK_DOWN: w = '{uop: U_LINK_DOWN,  jmp: J_GOTO,     target: PC_FINISH};
      PC_PUSH:         w = '{uop: U_PUSH_CHECK, jmp: J_BRANCH,   target: PC_FINISH};
      PC_PHASE:        w = '{uop: U_ADD_PHASE,  jmp: J_NEXT,     target: PC_EMIT};
      PC_EMIT:         w = '{uop: U_EMIT,       jmp: J_LOOP,     target: PC_FINISH};
      PC_PULL:         w = '{uop: U_PULL_READ,  jmp: J_BRANCH,   target: PC_FINISH};
      PC_TAKE:         w = '{uop: U_PULL_TAKE,  jmp: J_NEXT,     target: PC_FINISH};
      PC_FINISH:       w = '{uop: U_FINISH,     jmp: J_LOOP,     target: PC_ACCEPT};
      default:         w = '{uop: U_NOP,        jmp: J_GOTO,     target: PC_ACCEPT};
    endcase
    return w;
  endfunction

  function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
    logic [RATE_W-1:0] c;
    c = r;
    if (r < RATE_MIN) begin
      c = RATE_MIN;
    end else if (r > RATE_MAX) begin
      c = RATE_MAX;
    end
    return c;
  endfunction

endpackage

// ===== rtl/pcm_upsample_frame_fifo_unit.sv =====
// Each item is dispatched by opcode. A push checks the link; if it is down, the push is
// refused, else the phase is added and the frame loop writes one frame per pass. A pull
// reads the ring and takes the frame unless it underruns; link up or link down clears
// the ring. One item is in work at a time; the next waits until the result is registered.
// Reset is asynchronous and active low; the frame store is not cleared, and the fill
// count guards every read, so no clearing pass is needed.
module pcm_upsample_frame_fifo_unit #(
  parameter int RING_FRAMES = 2048
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcmup_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pcmup_pkg::RATE_W-1:0]    cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pcmup_pkg::in_t                  in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pcmup_pkg::out_t                 out_data_o
);
  import pcmup_pkg::*;

  localparam int PW = $clog2(RING_FRAMES);

  ctrl_t               ctrl;
  logic                cond;
  op_e                 opcode;
  logic                ram_we;
  logic [PW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [PW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  assign in_stall_o = (ctrl.uop != U_ACCEPT);

  pcmup_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .opcode_i (opcode),
    .cond_i   (cond),
    .ctrl_o   (ctrl)
  );

  pcmup_dp #(
    .RING_FRAMES (RING_FRAMES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .cond_o      (cond),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .opcode_o    (opcode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  pcmup_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_FRAMES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== rtl/pcmup_ram.sv =====
module pcmup_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pcmup_seq.sv =====
module pcmup_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pcmup_pkg::op_e   opcode_i,
  input  logic             cond_i,
  output pcmup_pkg::ctrl_t ctrl_o
);
  import pcmup_pkg::*;

  logic [PC_W-1:0] pc_q;
  logic [PC_W-1:0] pc_d;
  ucode_t          word;

  assign word = ucode(pc_q);
  assign ctrl_o.uop = word.uop;

  always_comb begin
    pc_d = pc_q;
    unique case (word.jmp)
      J_NEXT:     pc_d = pc_q + 1'b1;
      J_GOTO:     pc_d = word.target;
      J_DISPATCH: pc_d = word.target + PC_W'(opcode_i);
      J_BRANCH:   pc_d = cond_i ? word.target : pc_q + 1'b1;
      J_LOOP:     pc_d = cond_i ? pc_q : word.target;
      default:    pc_d = PC_ACCEPT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_ACCEPT;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/pcmup_dp.sv =====
module pcmup_dp #(
  parameter int RING_FRAMES = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pcmup_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pcmup_pkg::RATE_W-1:0]        cfg_wdata_i,
  input  pcmup_pkg::ctrl_t                    ctrl_i,
  output logic                                cond_o,
  input  logic                                in_valid_i,
  input  pcmup_pkg::in_t                      in_data_i,
  output pcmup_pkg::op_e                      opcode_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pcmup_pkg::out_t                     out_data_o,
  output logic                                ram_we_o,
  output logic [$clog2(RING_FRAMES)-1:0]      ram_waddr_o,
  output logic [pcmup_pkg::SAMPLE_W-1:0]      ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(RING_FRAMES)-1:0]      ram_raddr_o,
  input  logic [pcmup_pkg::SAMPLE_W-1:0]      ram_rdata_i
);
  import pcmup_pkg::*;

  localparam int PW = $clog2(RING_FRAMES);
  localparam int CW = $clog2(RING_FRAMES + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_FRAMES - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(RING_FRAMES);

  logic [RATE_W-1:0]   orate_q, orate_d;
  logic [RATE_W-1:0]   irate_q, irate_d;
  logic [RATE_W-1:0]   irate_use_q, irate_use_d;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [PW-1:0]       rp_q, rp_d;
  logic [PW-1:0]       wp_q, wp_d;
  logic [CW-1:0]       count_q, count_d;
  logic                link_q, link_d;
  in_t                 item_q, item_d;
  logic [SAMPLE_W-1:0] left_q, left_d;
  logic                under_q, under_d;
  logic [CNT4_W-1:0]   made_q, made_d;
  logic [CNT4_W-1:0]   dropped_q, dropped_d;
  logic                status_q, status_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                can_emit;
  logic                full;
  logic                empty;
  logic                out_free;
  logic [PW-1:0]       rp_inc;
  logic [PW-1:0]       wp_inc;
  logic [31:0]         count_ext;

  assign full      = (count_q == CNT_FULL);
  assign empty     = (count_q == '0);
  assign can_emit  = ({1'b0, irate_use_q} <= acc_q) && (made_q < MAX_FRAMES);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign rp_inc    = (rp_q == PTR_LAST) ? '0 : rp_q + 1'b1;
  assign wp_inc    = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
  assign count_ext = 32'(count_q);

  always_comb begin
    cond_o = 1'b0;
    unique case (ctrl_i.uop)
      U_ACCEPT:     cond_o = !in_valid_i;
      U_PUSH_CHECK: cond_o = !link_q;
      U_EMIT:       cond_o = can_emit;
      U_PULL_READ:  cond_o = empty;
      U_FINISH:     cond_o = !out_free;
      default:      cond_o = 1'b0;
    endcase
  end

  assign opcode_o    = item_q.opcode;
  assign ram_we_o    = (ctrl_i.uop == U_EMIT) && can_emit;
  assign ram_waddr_o = wp_q;
  assign ram_wdata_o = item_q.sample_in;
  assign ram_re_o    = (ctrl_i.uop == U_PULL_READ) && !empty;
  assign ram_raddr_o = rp_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    orate_d     = orate_q;
    irate_d     = irate_q;
    irate_use_d = irate_use_q;
    acc_d       = acc_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    count_d     = count_q;
    link_d      = link_q;
    item_d      = item_q;
    left_d      = left_q;
    under_d     = under_q;
    made_d      = made_q;
    dropped_d   = dropped_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OUTPUT_RATE:  orate_d = cfg_wdata_i;
        REG_INPUT_RATE:   irate_d = cfg_wdata_i;
        // The left sample is the pushed sample in both formats.
        REG_INPUT_STEREO: orate_d = orate_q;
        default:          orate_d = orate_q;
      endcase
    end

    unique case (ctrl_i.uop)
      U_ACCEPT: begin
        if (in_valid_i) begin
          item_d    = in_data_i;
          left_d    = '0;
          under_d   = 1'b0;
          made_d    = '0;
          dropped_d = '0;
          status_d  = 1'b0;
        end
      end
      U_LINK_UP, U_LINK_DOWN: begin
        link_d  = (ctrl_i.uop == U_LINK_UP);
        rp_d    = '0;
        wp_d    = '0;
        count_d = '0;
      end
      U_PUSH_CHECK: begin
        if (!link_q) begin
          status_d = 1'b1;
        end
      end
      U_ADD_PHASE: begin
        acc_d       = acc_q + ACC_W'(clamp_rate(orate_q));
        irate_use_d = clamp_rate(irate_q);
      end
      U_EMIT: begin
        if (can_emit) begin
          acc_d  = acc_q - {1'b0, irate_use_q};
          wp_d   = wp_inc;
          made_d = made_q + 1'b1;
          if (full) begin
            rp_d      = rp_inc;
            dropped_d = dropped_q + 1'b1;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      U_PULL_READ: begin
        if (empty) begin
          under_d = 1'b1;
        end
      end
      U_PULL_TAKE: begin
        left_d  = ram_rdata_i;
        rp_d    = rp_inc;
        count_d = count_q - 1'b1;
      end
      U_FINISH: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.left_out       = left_q;
          out_d.right_out      = left_q;
          out_d.underrun       = under_q;
          out_d.frames_made    = made_q;
          out_d.frames_dropped = dropped_q;
          out_d.status         = status_q;
          out_d.fill_level     = count_ext[FILL_W-1:0];
        end
      end
      default: begin
        out_d = out_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orate_q     <= OUTPUT_RATE_RST;
      irate_q     <= INPUT_RATE_RST;
      acc_q       <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      count_q     <= '0;
      link_q      <= 1'b0;
      under_q     <= 1'b0;
      made_q      <= '0;
      dropped_q   <= '0;
      status_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      orate_q     <= orate_d;
      irate_q     <= irate_d;
      acc_q       <= acc_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      count_q     <= count_d;
      link_q      <= link_d;
      under_q     <= under_d;
      made_q      <= made_d;
      dropped_q   <= dropped_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    irate_use_q <= irate_use_d;
    item_q      <= item_d;
    left_q      <= left_d;
    out_q       <= out_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("Frame count exceeds the ring size.");

  a_made_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    made_q <= MAX_FRAMES)
    else $error("Too many frames emitted for one item.");

  a_emit_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> link_q)
    else $error("Frame written while the link is down.");

  a_full_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we_o && full) |=> (count_q == CNT_FULL))
    else $error("Overwrite of the oldest frame changed the count.");
`endif

endmodule

// ===== bench/pcmup_frame_checker.sv =====
`timescale 1ns / 1ps
module pcmup_frame_checker
  import pcmup_pkg::*;
#(
  parameter int RING_FRAMES = 2048
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [RATE_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_t                 out_data_i,
  output int                   errors_o,
  output int                   pending_o,
  output int                   results_o,
  output int                   overwritten_o,
  output int                   underruns_o,
  output int                   refused_o,
  output int                   peak_fill_o
);

  logic [RATE_W-1:0]          out_rate_q;
  logic [RATE_W-1:0]          in_rate_q;
  logic                       stereo_q;
  logic signed [SAMPLE_W-1:0] ring_mem [RING_FRAMES];
  int unsigned                rd_ptr;
  int unsigned                wr_ptr;
  int unsigned                held_frames;
  logic [ACC_W-1:0]           phase_acc;
  logic                       link_q;
  out_t                       pending_results_q[$];

  task automatic resample_step(input in_t item, output out_t res);
    logic [RATE_W-1:0] orate;
    logic [RATE_W-1:0] irate;
    res = '0;
    case (item.opcode)
      OP_PUSH: begin
        if (!link_q) begin
          res.status = 1'b1;
        end else begin
          orate = (out_rate_q < RATE_MIN) ? RATE_MIN :
                  (out_rate_q > RATE_MAX) ? RATE_MAX : out_rate_q;
          irate = (in_rate_q < RATE_MIN) ? RATE_MIN :
                  (in_rate_q > RATE_MAX) ? RATE_MAX : in_rate_q;
          phase_acc = phase_acc + ACC_W'(orate);
          while (phase_acc >= ACC_W'(irate) && res.frames_made < MAX_FRAMES) begin
            phase_acc = phase_acc - ACC_W'(irate);
            if (held_frames >= RING_FRAMES) begin
              rd_ptr = (rd_ptr + 1) % RING_FRAMES;
              held_frames = held_frames - 1;
              res.frames_dropped = res.frames_dropped + 1'b1;
            end
            ring_mem[wr_ptr] = item.sample_in;
            wr_ptr = (wr_ptr + 1) % RING_FRAMES;
            held_frames = held_frames + 1;
            res.frames_made = res.frames_made + 1'b1;
          end
        end
      end
      OP_PULL: begin
        if (held_frames > 0) begin
          res.left_out = ring_mem[rd_ptr];
          res.right_out = ring_mem[rd_ptr];
          rd_ptr = (rd_ptr + 1) % RING_FRAMES;
          held_frames = held_frames - 1;
        end else begin
          res.underrun = 1'b1;
        end
      end
      OP_LINK_UP: begin
        link_q = 1'b1;
        rd_ptr = 0;
        wr_ptr = 0;
        held_frames = 0;
      end
      default: begin
        link_q = 1'b0;
        rd_ptr = 0;
        wr_ptr = 0;
        held_frames = 0;
      end
    endcase
    res.fill_level = FILL_W'(held_frames);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    out_t got;
    logic bad;
    if (!rst_ni) begin
      out_rate_q = OUTPUT_RATE_RST;
      in_rate_q = INPUT_RATE_RST;
      stereo_q = 1'b0;
      rd_ptr = 0;
      wr_ptr = 0;
      held_frames = 0;
      phase_acc = '0;
      link_q = 1'b0;
      pending_results_q.delete();
      errors_o = 0;
      pending_o = 0;
      results_o = 0;
      overwritten_o = 0;
      underruns_o = 0;
      refused_o = 0;
      peak_fill_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        results_o++;
        if (pending_results_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) begin
            $display("%0t: result with no item outstanding: L=%0d fill=%0d",
                     $realtime, got.left_out, got.fill_level);
          end
        end else begin
          want = pending_results_q.pop_front();
          bad = (got.left_out !== want.left_out) || (got.right_out !== want.right_out) ||
                (got.underrun !== want.underrun) ||
                (got.frames_made !== want.frames_made) ||
                (got.frames_dropped !== want.frames_dropped) ||
                (got.status !== want.status) || (got.fill_level !== want.fill_level);
          if (bad) begin
            errors_o++;
            if (errors_o <= 10) begin
              $display("%0t: mismatch: expected L=%0d R=%0d und=%0b made=%0d drop=%0d st=%0b fill=%0d",
                       $realtime, want.left_out, want.right_out, want.underrun,
                       want.frames_made, want.frames_dropped, want.status, want.fill_level);
              $display("%0t:           actual   L=%0d R=%0d und=%0b made=%0d drop=%0d st=%0b fill=%0d",
                       $realtime, got.left_out, got.right_out, got.underrun,
                       got.frames_made, got.frames_dropped, got.status, got.fill_level);
            end
          end
          overwritten_o += want.frames_dropped;
          underruns_o += want.underrun;
          refused_o += want.status;
          if (want.fill_level > peak_fill_o) begin
            peak_fill_o = want.fill_level;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_OUTPUT_RATE:  out_rate_q = cfg_wdata_i;
          REG_INPUT_RATE:   in_rate_q = cfg_wdata_i;
          REG_INPUT_STEREO: stereo_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        resample_step(in_data_i, want);
        pending_results_q.push_back(want);
      end
      pending_o = pending_results_q.size();
    end
  end

endmodule

// ===== bench/tb_pcm_upsample_frame_fifo_unit.sv =====
`timescale 1ns / 1ps
module tb_pcm_upsample_frame_fifo_unit;
  import pcmup_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES = 8;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [RATE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int holds_served;
  int errors;
  int pending;
  int results;
  int overwritten;
  int underruns;
  int refused;
  int peak_fill;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  pcm_upsample_frame_fifo_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pcmup_frame_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .errors_o      (errors),
    .pending_o     (pending),
    .results_o     (results),
    .overwritten_o (overwritten),
    .underruns_o   (underruns),
    .refused_o     (refused),
    .peak_fill_o   (peak_fill)
  );

  function automatic in_t mk(input op_e op, input logic signed [SAMPLE_W-1:0] s);
    in_t it;
    it.opcode = op;
    it.sample_in = s;
    return it;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] s;
    s = SAMPLE_W'($urandom);
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0: s = 16'sh7fff;
        1: s = 16'sh8000;
        2: s = 16'sh0000;
        default: s = 16'shffff;
      endcase
    end
    return s;
  endfunction

  function automatic in_t pick_item(input bit fill_heavy);
    int r;
    op_e op;
    r = $urandom_range(999);
    if (fill_heavy) begin
      op = (r < 850) ? OP_PUSH : (r < 997) ? OP_PULL : (r < 999) ? OP_LINK_UP : OP_LINK_DOWN;
    end else begin
      op = (r < 450) ? OP_PUSH : (r < 920) ? OP_PULL : (r < 970) ? OP_LINK_UP : OP_LINK_DOWN;
    end
    return mk(op, pick_sample());
  endfunction

  task automatic send_item(input in_t it);
    int idle;
    idle = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      idle++;
    end
    @(negedge clk);
    if (idle > 0) begin
      in_valid = 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
  endtask

  task automatic configure(input logic [RATE_W-1:0] orate, input logic [RATE_W-1:0] irate,
                           input logic stereo);
    write_reg(REG_OUTPUT_RATE, orate);
    write_reg(REG_INPUT_RATE, irate);
    write_reg(REG_INPUT_STEREO, RATE_W'(stereo));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    out_stall = 1'b0;
    holds_served = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_served++;
      end
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_pcm_upsample_frame_fifo_unit: FAIL");
    $finish;
  end

  initial begin
    int n_items;
    bit fill_heavy;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Reset rates: link-down handling, sample extremes, clearing by link events.
    send_item(mk(OP_PULL, 16'sh0000));
    send_item(mk(OP_PUSH, 16'sh7fff));
    send_item(mk(OP_LINK_DOWN, 16'sh0000));
    send_item(mk(OP_LINK_UP, 16'sh0000));
    send_item(mk(OP_PULL, 16'sh0000));
    send_item(mk(OP_PUSH, 16'sh7fff));
    send_item(mk(OP_PUSH, 16'sh8000));
    send_item(mk(OP_PUSH, 16'sh0000));
    send_item(mk(OP_PUSH, 16'shffff));
    send_item(mk(OP_PULL, 16'sh0000));
    send_item(mk(OP_PULL, 16'sh0000));
    send_item(mk(OP_LINK_UP, 16'sh0000));
    send_item(mk(OP_PUSH, 16'sh1234));
    send_item(mk(OP_PULL, 16'sh0000));
    send_item(mk(OP_LINK_DOWN, 16'sh0000));
    send_item(mk(OP_PULL, 16'sh0000));
    send_item(mk(OP_PUSH, 16'sh5a5a));
    drain();

    // Out-of-range rates clamp to the slowest output and fastest input,
    // so the first pushes make no frames and the phase builds up.
    configure(RATE_W'(0), RATE_W'(131071), 1'b1);
    send_item(mk(OP_LINK_UP, 16'sh0000));
    send_item(mk(OP_PUSH, 16'sh2222));
    send_item(mk(OP_PUSH, 16'sh3333));
    drain();

    // Lowering the input rate with phase left over hits the per-push frame cap.
    configure(RATE_W'(96001), RATE_W'(7999), 1'b0);
    send_item(mk(OP_PUSH, 16'sh4444));
    send_item(mk(OP_PUSH, 16'sh5555));
    send_item(mk(OP_PULL, 16'sh0000));
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      fill_heavy = 1'b0;
      n_items = 170;
      case (p)
        0: configure(RATE_W'(48000), RATE_W'(8000), 1'b0);
        1: begin
          configure(RATE_MAX, RATE_MIN, 1'b1);
          fill_heavy = 1'b1;
        end
        2: configure(RATE_W'($urandom_range(8000, 96000)),
                     RATE_W'($urandom_range(8000, 96000)), 1'(($urandom)));
        3: configure(RATE_MIN, RATE_MAX, 1'b0);
        4: begin
          configure(RATE_W'(131071), RATE_W'(0), 1'b1);
          fill_heavy = 1'b1;
        end
        5: configure(RATE_W'($urandom_range(8000, 96000)),
                     RATE_W'($urandom_range(8000, 96000)), 1'b1);
        6: configure(OUTPUT_RATE_RST, INPUT_RATE_RST, 1'b0);
        default: begin
          configure(RATE_MAX, RATE_W'($urandom_range(8000, 12000)), 1'b0);
          fill_heavy = 1'b1;
        end
      endcase
      if (fill_heavy) begin
        n_items = 300;
      end
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 79;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 79;
        end
        default: begin
          send_idle_pct = 22;
          recv_stall_pct = 22;
        end
      endcase
      send_item(mk(OP_LINK_UP, 16'sh0000));
      for (int i = 1; i < n_items; i++) begin
        if ((p == 1 && i == 100) || (p == 6 && i == 50)) begin
          hold_requests++;
        end
        send_item(pick_item(fill_heavy));
      end
      drain();
    end

    repeat (30) @(negedge clk);
    $display("Checked %0d results over %0d rate settings; ring peaked at %0d frames, %0d overwritten.",
             results, NUM_PHASES + 3, peak_fill, overwritten);
    $display("Pulls that underran: %0d; pushes refused with the link down: %0d.",
             underruns, refused);
    if (errors == 0 && pending == 0) begin
      $display("tb_pcm_upsample_frame_fifo_unit: PASS");
    end else begin
      $display("tb_pcm_upsample_frame_fifo_unit: FAIL");
    end
    $finish;
  end

endmodule
